// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/rcf_pkg.sv -----
// Package for the card command framer: request and result types, frame constants
// and the control bundle between the sequencer and the CRC unit. No dependencies.
`default_nettype none

package rcf_pkg;

    // Frame header constants.
    localparam logic [7:0]  READ_LEN         = 8'h06;
    localparam logic [7:0]  READ_CMD         = 8'h12;
    localparam logic [7:0]  WRITE_LEN        = 8'h0A;
    localparam logic [7:0]  WRITE_CMD        = 8'h10;
    localparam logic [7:0]  CARD_ADDR_RESET  = 8'hFF;

    // CRC-16/XMODEM.
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] CRC_INIT         = 16'h0000;

    // Command kinds.
    localparam logic        KIND_READ        = 1'b0;
    localparam logic        KIND_WRITE       = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] sector;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [7:0] data_three;
        logic [7:0] data_four;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_result;

    // Control from the sequencer to the CRC unit.
    typedef struct packed {
        logic       clear;
        logic       update;
        logic [7:0] data_byte;
    } t_crc_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/rfid_command_framer_crc16.sv -----
// Top level of the card command framer: card address register, sequencer and CRC unit.
// Depends on rcf_pkg, rcf_sequencer and rcf_crc_unit.
//
//  channel   handshake              payload      direction
//  request   start / busy           i_cmd        in
//  result    o_strobe (no stall)    o_result     out
//  config    i_cfg_we               i_cfg_data   in
//
// A read request gives 6 result bytes, a write request 10, one per cycle starting
// the cycle after the request is taken; the byte sequencer sets this figure.
// Busy is low on the final byte, so a new request can be taken at the edge that
// ends it. Reset is synchronous, active low; the card address resets to 0xFF.
// The receiver cannot stall: every result is valid for exactly one cycle.
`default_nettype none

module rfid_command_framer_crc16 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rcf_pkg::t_cmd     i_cmd,
    output logic                   o_strobe,
    output rcf_pkg::t_result       o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_data
);
    import rcf_pkg::*;

    logic [7:0] r_card_address;
    logic [15:0] crc;
    t_crc_ctl   crc_ctl;

    // Card address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_address <= CARD_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_card_address <= i_cfg_data;
        end
    end

    rcf_sequencer u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (i_cmd),
        .i_card_address (r_card_address),
        .i_crc          (crc),
        .o_busy         (busy),
        .o_strobe       (o_strobe),
        .o_result       (o_result),
        .o_crc_ctl      (crc_ctl)
    );

    rcf_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rcf_crc_unit.sv -----
// Shared CRC-16/XMODEM unit: folds one body byte per cycle, while update is set, into the running CRC.
// Depends on rcf_pkg.
`default_nettype none

module rcf_crc_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rcf_pkg::t_crc_ctl i_ctl,
    output logic [15:0]            o_crc
);
    import rcf_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // One byte of the MSB-first CRC: eight shift-and-xor steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Clear on a new request, otherwise accumulate body bytes.
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.clear) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.update) begin
            n_crc = crc_byte(r_crc, i_ctl.data_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

// ----- hw/rtl/rcf_sequencer.sv -----
// Frame sequencer: holds the accepted request, steps through the frame one byte per
// cycle and drives the CRC unit. Depends on rcf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rcf_sequencer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire rcf_pkg::t_cmd     i_cmd,
    input  wire logic [7:0]        i_card_address,
    input  wire logic [15:0]       i_crc,
    output logic                   o_busy,
    output logic                   o_strobe,
    output rcf_pkg::t_result       o_result,
    output rcf_pkg::t_crc_ctl      o_crc_ctl
);
    import rcf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BODY   = 2'd1;
    localparam logic [1:0] ST_CRC_HI = 2'd2;
    localparam logic [1:0] ST_CRC_LO = 2'd3;

    localparam logic [2:0] READ_LAST_IDX  = 3'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic       accept;
    logic [2:0] last_idx;
    logic [7:0] body_byte;
    logic       at_first_byte;

    assign accept   = i_start && !o_busy;
    assign last_idx = (r_cmd.kind == KIND_WRITE) ? WRITE_LAST_IDX : READ_LAST_IDX;

    // Busy drops on the final byte so the next request can follow at once.
    assign o_busy   = (r_state == ST_BODY) || (r_state == ST_CRC_HI);

    // Select the body byte for the current position.
    always_comb begin
        unique case (r_idx)
            3'd0: body_byte = i_card_address;
            3'd1: body_byte = (r_cmd.kind == KIND_WRITE) ? WRITE_LEN : READ_LEN;
            3'd2: body_byte = (r_cmd.kind == KIND_WRITE) ? WRITE_CMD : READ_CMD;
            3'd3: body_byte = (r_cmd.kind == KIND_WRITE) ? r_cmd.data_one : r_cmd.sector;
            3'd4: body_byte = r_cmd.data_two;
            3'd5: body_byte = r_cmd.data_three;
            3'd6: body_byte = r_cmd.data_four;
            default: body_byte = r_cmd.sector;
        endcase
    end

    // Next state: walk the body, then both CRC bytes.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cmd   = r_cmd;
        unique case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_BODY: begin
                if (r_idx == last_idx) begin
                    n_state = ST_CRC_HI;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_CRC_HI: begin
                n_state = ST_CRC_LO;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (accept) begin
            n_state = ST_BODY;
            n_idx   = 3'd0;
            n_cmd   = i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // The request itself needs no reset.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // CRC unit control: restart on a new request, fold in body bytes only.
    assign o_crc_ctl.clear     = accept;
    assign o_crc_ctl.update    = (r_state == ST_BODY);
    assign o_crc_ctl.data_byte = body_byte;

    // Result output.
    assign o_strobe = (r_state != ST_IDLE);
    always_comb begin
        unique case (r_state)
            ST_CRC_HI: o_result.frame_byte = i_crc[15:8];
            ST_CRC_LO: o_result.frame_byte = i_crc[7:0];
            default:   o_result.frame_byte = body_byte;
        endcase
        o_result.last_byte = (r_state == ST_CRC_LO);
    end

    // Checks.
    assign at_first_byte = (r_state == ST_BODY) && (r_idx == 3'd0);

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, o_strobe && at_first_byte)
    `ASSERT_NEXT(a_hi_then_lo, i_clk, i_rst_n, r_state == ST_CRC_HI, o_strobe && o_result.last_byte)
    `ASSERT_NEXT(a_quiet_after_last, i_clk, i_rst_n, o_result.last_byte && !accept, !o_strobe)
    `ASSERT_IMPLIES(a_no_update_outside_body, i_clk, i_rst_n, r_state != ST_BODY, !o_crc_ctl.update)
    `ASSERT_IMPLIES(a_body_index_bound, i_clk, i_rst_n, r_state == ST_BODY, r_idx <= last_idx)

endmodule

`default_nettype wire
